FILE: hw/rtl/gda_pkg.sv
`timescale 1ns / 1ps
// Shared types, microcode encoding and calendar helpers for the date adder.
// No dependencies; used by every module of the block.
package gda_pkg;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] gda_upc_t;

    // Step addresses of the microprogram
    localparam gda_upc_t STEP_WAIT    = 4'd0;
    localparam gda_upc_t STEP_REDUCE  = 4'd1;
    localparam gda_upc_t STEP_CHECK   = 4'd2;
    localparam gda_upc_t STEP_ADD     = 4'd3;
    localparam gda_upc_t STEP_MONTH   = 4'd4;
    localparam gda_upc_t STEP_EMIT    = 4'd5;
    localparam gda_upc_t STEP_DONE    = 4'd6;
    localparam gda_upc_t STEP_ERROR   = 4'd7;
    localparam gda_upc_t STEP_ERRDONE = 4'd8;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 16;
    localparam int ACC_W   = ADD_W + 1;
    localparam int CYC_W   = 9;

    localparam logic [YEAR_W-1:0] CYCLE_YEARS = 14'd400;
    localparam logic [YEAR_W-1:0] CYCLE_LAST  = 14'd399;
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd16383;
    localparam logic [CYC_W-1:0]  CENTURY_1   = 9'd100;
    localparam logic [CYC_W-1:0]  CENTURY_2   = 9'd200;
    localparam logic [CYC_W-1:0]  CENTURY_3   = 9'd300;
    localparam logic [MON_W-1:0]  MON_FEB     = 4'd2;
    localparam logic [MON_W-1:0]  MON_APR     = 4'd4;
    localparam logic [MON_W-1:0]  MON_JUN     = 4'd6;
    localparam logic [MON_W-1:0]  MON_SEP     = 4'd9;
    localparam logic [MON_W-1:0]  MON_NOV     = 4'd11;
    localparam logic [MON_W-1:0]  MON_DEC     = 4'd12;
    localparam logic [MON_W-1:0]  MON_JAN     = 4'd1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUB400,
        OP_ADDDAY,
        OP_MONTH,
        OP_EMIT,
        OP_ERROR
    } gda_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_REM_GE400,
        C_BAD,
        C_NOT_FITS,
        C_OUT_BUSY
    } gda_cond_t;

    typedef struct packed {
        gda_op_t   op;
        gda_cond_t cond;
        gda_upc_t  target;
    } gda_uword_t;

    // Datapath flags seen by the jump logic
    typedef struct packed {
        logic rem_ge400;
        logic bad;
        logic fits;
        logic out_free;
    } gda_status_t;

    // Leap status from the year's position in the 400-year cycle
    function automatic logic is_leap(input logic [CYC_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2)
            && (r != CENTURY_3);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MON_FEB)
            len = leap ? 5'd29 : 5'd28;
        else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
            len = 5'd30;
        return len;
    endfunction

endpackage

FILE: hw/rtl/gda_ucode_rom.sv
`timescale 1ns / 1ps
// Microprogram store: one control word per step address.
// Depends on gda_pkg for the word layout and step names.
module gda_ucode_rom (
    input  gda_pkg::gda_upc_t   upc,
    output gda_pkg::gda_uword_t uword
);

    always_comb
    begin
        unique case (upc)
            gda_pkg::STEP_WAIT:
                uword = '{gda_pkg::OP_LOAD, gda_pkg::C_NO_INPUT, gda_pkg::STEP_WAIT};
            gda_pkg::STEP_REDUCE:
                uword = '{gda_pkg::OP_SUB400, gda_pkg::C_REM_GE400, gda_pkg::STEP_REDUCE};
            gda_pkg::STEP_CHECK:
                uword = '{gda_pkg::OP_NONE, gda_pkg::C_BAD, gda_pkg::STEP_ERROR};
            gda_pkg::STEP_ADD:
                uword = '{gda_pkg::OP_ADDDAY, gda_pkg::C_NEVER, gda_pkg::STEP_WAIT};
            gda_pkg::STEP_MONTH:
                uword = '{gda_pkg::OP_MONTH, gda_pkg::C_NOT_FITS, gda_pkg::STEP_MONTH};
            gda_pkg::STEP_EMIT:
                uword = '{gda_pkg::OP_EMIT, gda_pkg::C_OUT_BUSY, gda_pkg::STEP_EMIT};
            gda_pkg::STEP_DONE:
                uword = '{gda_pkg::OP_NONE, gda_pkg::C_ALWAYS, gda_pkg::STEP_WAIT};
            gda_pkg::STEP_ERROR:
                uword = '{gda_pkg::OP_ERROR, gda_pkg::C_OUT_BUSY, gda_pkg::STEP_ERROR};
            gda_pkg::STEP_ERRDONE:
                uword = '{gda_pkg::OP_NONE, gda_pkg::C_ALWAYS, gda_pkg::STEP_WAIT};
            default:
                uword = '{gda_pkg::OP_NONE, gda_pkg::C_ALWAYS, gda_pkg::STEP_WAIT};
        endcase
    end

endmodule

FILE: hw/rtl/gda_sequencer.sv
`timescale 1ns / 1ps
// Step counter with conditional jumps; fetches the control word from the ROM.
// Depends on gda_pkg and gda_ucode_rom.
module gda_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  gda_pkg::gda_status_t status,
    output gda_pkg::gda_op_t     op
);

    gda_pkg::gda_upc_t   upc_reg;
    gda_pkg::gda_upc_t   upc_next;
    gda_pkg::gda_uword_t uword;
    logic                take;

    gda_ucode_rom u_rom (
        .upc   (upc_reg),
        .uword (uword)
    );

    always_comb
    begin
        unique case (uword.cond)
            gda_pkg::C_NEVER:     take = 1'b0;
            gda_pkg::C_ALWAYS:    take = 1'b1;
            gda_pkg::C_NO_INPUT:  take = !in_valid;
            gda_pkg::C_REM_GE400: take = status.rem_ge400;
            gda_pkg::C_BAD:       take = status.bad;
            gda_pkg::C_NOT_FITS:  take = !status.fits;
            gda_pkg::C_OUT_BUSY:  take = !status.out_free;
            default:              take = 1'b0;
        endcase
        upc_next = take ? uword.target : upc_reg + gda_pkg::gda_upc_t'(1);
    end

    assign op = uword.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= gda_pkg::STEP_WAIT;
        else
            upc_reg <= upc_next;
    end

endmodule

FILE: hw/rtl/gda_datapath.sv
`timescale 1ns / 1ps
// Working registers, month-length logic and the output register.
// Depends on gda_pkg for op codes, status layout and calendar functions.
module gda_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gda_pkg::gda_op_t     op,
    input  logic                 in_valid,
    input  logic [4:0]           start_day,
    input  logic [3:0]           start_month,
    input  logic [13:0]          start_year,
    input  logic [15:0]          days_to_add,
    input  logic                 out_stall,
    output gda_pkg::gda_status_t status,
    output logic                 out_valid,
    output logic [4:0]           result_day,
    output logic [3:0]           result_month,
    output logic [13:0]          result_year,
    output logic                 bad_input
);

    logic [gda_pkg::ACC_W-1:0]  day_reg,  day_next;
    logic [gda_pkg::MON_W-1:0]  mon_reg,  mon_next;
    logic [gda_pkg::YEAR_W-1:0] yr_reg,   yr_next;
    logic [gda_pkg::YEAR_W-1:0] rem_reg,  rem_next;
    logic [gda_pkg::ADD_W-1:0]  add_reg,  add_next;
    logic [gda_pkg::DAY_W-1:0]  rday_reg, rday_next;
    logic [gda_pkg::MON_W-1:0]  rmon_reg, rmon_next;
    logic [gda_pkg::YEAR_W-1:0] ryr_reg,  ryr_next;
    logic                       rbad_reg, rbad_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       leap;
    logic [gda_pkg::DAY_W-1:0]  mlen;
    logic                       out_write;

    always_comb
    begin
        leap = gda_pkg::is_leap(rem_reg[gda_pkg::CYC_W-1:0]);
        mlen = gda_pkg::month_len(mon_reg, leap);
        status.rem_ge400 = rem_reg >= gda_pkg::CYCLE_YEARS;
        status.fits      = day_reg <= gda_pkg::ACC_W'(mlen);
        status.bad       = (mon_reg == '0) || (mon_reg > gda_pkg::MON_DEC)
                        || (day_reg == '0) || (day_reg > gda_pkg::ACC_W'(mlen));
        status.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        day_next  = day_reg;
        mon_next  = mon_reg;
        yr_next   = yr_reg;
        rem_next  = rem_reg;
        add_next  = add_reg;
        rday_next = rday_reg;
        rmon_next = rmon_reg;
        ryr_next  = ryr_reg;
        rbad_next = rbad_reg;
        out_write = 1'b0;
        unique case (op)
            gda_pkg::OP_NONE:
            begin
            end
            gda_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    day_next = gda_pkg::ACC_W'(start_day);
                    mon_next = start_month;
                    yr_next  = start_year;
                    rem_next = start_year;
                    add_next = days_to_add;
                end
            end
            gda_pkg::OP_SUB400:
            begin
                if (status.rem_ge400)
                    rem_next = rem_reg - gda_pkg::CYCLE_YEARS;
            end
            gda_pkg::OP_ADDDAY:
                day_next = day_reg + gda_pkg::ACC_W'(add_reg);
            gda_pkg::OP_MONTH:
            begin
                if (!status.fits)
                begin
                    day_next = day_reg - gda_pkg::ACC_W'(mlen);
                    if (mon_reg == gda_pkg::MON_DEC)
                    begin
                        mon_next = gda_pkg::MON_JAN;
                        yr_next  = yr_reg + gda_pkg::YEAR_W'(1);
                        // wrap of the year counter lands on a cycle start too
                        if (yr_reg == gda_pkg::YEAR_MAX || rem_reg == gda_pkg::CYCLE_LAST)
                            rem_next = '0;
                        else
                            rem_next = rem_reg + gda_pkg::YEAR_W'(1);
                    end
                    else
                        mon_next = mon_reg + gda_pkg::MON_W'(1);
                end
            end
            gda_pkg::OP_EMIT:
            begin
                if (status.out_free)
                begin
                    out_write = 1'b1;
                    rday_next = day_reg[gda_pkg::DAY_W-1:0];
                    rmon_next = mon_reg;
                    ryr_next  = yr_reg;
                    rbad_next = 1'b0;
                end
            end
            gda_pkg::OP_ERROR:
            begin
                if (status.out_free)
                begin
                    out_write = 1'b1;
                    rday_next = '0;
                    rmon_next = '0;
                    ryr_next  = '0;
                    rbad_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (out_write)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        day_reg  <= day_next;
        mon_reg  <= mon_next;
        yr_reg   <= yr_next;
        rem_reg  <= rem_next;
        add_reg  <= add_next;
        rday_reg <= rday_next;
        rmon_reg <= rmon_next;
        ryr_reg  <= ryr_next;
        rbad_reg <= rbad_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_day   = rday_reg;
    assign result_month = rmon_reg;
    assign result_year  = ryr_reg;
    assign bad_input    = rbad_reg;

endmodule

FILE: hw/rtl/gregorian_date_add_days_unit.sv
`timescale 1ns / 1ps
// Gregorian date plus days, run by a microcoded sequencer over a small datapath.
// From acceptance to out_valid an item runs through reduce while the year copy is
// 400 or more, then check, add, month until the day fits its month, and emit.
// One item at a time; the next item is taken only after the result is written,
// via the done and wait steps, and the month-subtract step, one month per cycle,
// sets the rate. A stalled output holds the emit step. Invalid start dates go from
// check to the error step, which writes a result with bad_input set.
// Reset (rst_n low, async) returns the step counter to wait and drops out_valid.
module gregorian_date_add_days_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  start_day,
    input  logic [3:0]  start_month,
    input  logic [13:0] start_year,
    input  logic [15:0] days_to_add,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  result_day,
    output logic [3:0]  result_month,
    output logic [13:0] result_year,
    output logic        bad_input
);

    gda_pkg::gda_op_t     op;
    gda_pkg::gda_status_t status;

    // Step flow:
    //   wait    - load an item when one is offered
    //   reduce  - subtract 400 from a year copy until it falls below 400;
    //             the remainder gives leap status without a divider
    //   check   - jump to the error step on a bad month or day
    //   add     - add the day count to the day
    //   month   - drop one month length per cycle, advance month and year,
    //             and keep the 400-year position in step with the year
    //   emit    - hold until the output register is free, then write it
    gda_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .op       (op)
    );

    gda_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .in_valid     (in_valid),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .days_to_add  (days_to_add),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year),
        .bad_input    (bad_input)
    );

    // Take an item only in the wait step; the output register decouples the
    // next load from a result that still waits downstream.
    assign in_stall = (op != gda_pkg::OP_LOAD);

endmodule
